>>> sv/qkc_pkg.sv
package qkc_pkg;

    localparam int CACHE_ENTRIES_DEF = 64;
    localparam int QUANT_SHIFT_DEF   = 6;

    localparam int CMD_W     = 2;
    localparam int COORD_W   = 25;
    localparam int FILL_W    = 24;
    localparam int VAL_W     = 21;
    localparam int TOTAL_W   = 32;
    localparam int HELD_W    = 7;
    localparam int CAP_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 21;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 96;

    localparam logic signed [COORD_W-1:0] LAT_LIMIT = 25'sd5898240;
    localparam logic signed [COORD_W-1:0] LON_LIMIT = 25'sd11796480;

    localparam logic [CAP_W-1:0]         CAP_RESET   = 7'd64;
    localparam logic signed [VAL_W-1:0]  FLOOR_RESET = -21'sd1048576;
    localparam logic signed [VAL_W-1:0]  CEIL_RESET  = 21'sd1048575;
    localparam logic [TOTAL_W-1:0]       TOTAL_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACCESS      = 2'd0,
        CMD_CLR_ENTRIES = 2'd1,
        CMD_CLR_COUNTS  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY = 2'd0,
        REG_FLOOR    = 2'd1,
        REG_CEILING  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RES
    } t_state;

    typedef struct packed {
        logic shift;
        logic cmp_en;
    } t_cell_ctrl;

endpackage

>>> sv/quantized_key_fifo_value_cache_unit.sv
// an accepted item is registered, compared against every cell in S_CMP, and its result
// is loaded into the output register in S_RES once that register is free; the chain shifts
// on that load, and the or-reduction of the cell results between them is combinational
// the output register decouples the sink, so the next item is taken while a result waits
// reset: synchronous active low; clears entry count, counters, handshake state and
// loads capacity 64, floor -1048576, ceiling 1048575
module quantized_key_fifo_value_cache_unit
    import qkc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    parameter int QUANT_SHIFT   = QUANT_SHIFT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // latitude[24:0], longitude[49:25], fill_value[73:50], zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]     s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // value[20:0], was_hit[21], coords_ok[22], hit_total[54:23],
    // miss_total[86:55], entries_held[93:87], zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int HALF_W = COORD_W - QUANT_SHIFT;
    localparam int KEY_W  = 2 * HALF_W;
    localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);
    localparam int CW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // configuration
    logic [CAP_W-1:0]        r_cap;
    logic signed [VAL_W-1:0] r_floor;
    logic signed [VAL_W-1:0] r_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_floor <= FLOOR_RESET;
            r_ceil  <= CEIL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CAPACITY: r_cap   <= i_cfg_data[CAP_W-1:0];
                REG_FLOOR:    r_floor <= i_cfg_data;
                REG_CEILING:  r_ceil  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input decode
    logic signed [COORD_W-1:0] w_lat;
    logic signed [COORD_W-1:0] w_lon;
    logic signed [FILL_W-1:0]  w_fill;
    logic [COORD_W:0]          w_lat_abs;
    logic [COORD_W:0]          w_lon_abs;
    logic [COORD_W:0]          w_lat_q;
    logic [COORD_W:0]          w_lon_q;
    logic [KEY_W-1:0]          w_key;
    logic                      w_coords_ok;
    logic signed [FILL_W-1:0]  w_fill_c;
    logic signed [VAL_W-1:0]   w_fill_clamped;

    assign w_lat  = s_axis_tdata[COORD_W-1:0];
    assign w_lon  = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign w_fill = s_axis_tdata[2*COORD_W+FILL_W-1:2*COORD_W];

    // truncate toward zero: shift the magnitude, then restore the sign
    always_comb begin
        w_lat_abs = w_lat[COORD_W-1] ? -{w_lat[COORD_W-1], w_lat} : {1'b0, w_lat};
        w_lon_abs = w_lon[COORD_W-1] ? -{w_lon[COORD_W-1], w_lon} : {1'b0, w_lon};
        w_lat_q   = w_lat_abs >> QUANT_SHIFT;
        w_lon_q   = w_lon_abs >> QUANT_SHIFT;
        if (w_lat[COORD_W-1]) w_lat_q = -w_lat_q;
        if (w_lon[COORD_W-1]) w_lon_q = -w_lon_q;
        w_key = {w_lat_q[HALF_W-1:0], w_lon_q[HALF_W-1:0]};
    end

    assign w_coords_ok = (w_lat >= -LAT_LIMIT) && (w_lat <= LAT_LIMIT) &&
                         (w_lon >= -LON_LIMIT) && (w_lon <= LON_LIMIT);

    // ceiling first, then floor, so the floor wins when they cross
    always_comb begin
        w_fill_c = w_fill;
        if (w_fill_c > FILL_W'(r_ceil))  w_fill_c = FILL_W'(r_ceil);
        if (w_fill_c < FILL_W'(r_floor)) w_fill_c = FILL_W'(r_floor);
        w_fill_clamped = w_fill_c[VAL_W-1:0];
    end

    // control
    t_state                  r_state;
    t_state                  n_state;
    logic [CMD_W-1:0]        r_cmd;
    logic [KEY_W-1:0]        r_key;
    logic                    r_coords_ok;
    logic signed [VAL_W-1:0] r_fill;
    logic [CNT_W-1:0]        r_held;
    logic [CNT_W-1:0]        n_held;
    logic [TOTAL_W-1:0]      r_hits;
    logic [TOTAL_W-1:0]      n_hits;
    logic [TOTAL_W-1:0]      r_misses;
    logic [TOTAL_W-1:0]      n_misses;
    logic                    r_out_valid;
    logic [M_TDATA_W-1:0]    r_out_data;
    logic [M_TDATA_W-1:0]    n_out_data;
    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_finish;
    logic                    w_access;
    logic                    w_hit_any;
    logic                    w_full;
    logic [CW-1:0]           w_cap_eff;
    logic signed [VAL_W-1:0] w_hit_val;
    logic signed [VAL_W-1:0] w_res_val;
    t_cell_ctrl              w_ctrl;

    logic [CACHE_ENTRIES-1:0] w_hit;
    logic [CACHE_ENTRIES-1:0] w_valid;
    logic [KEY_W-1:0]         w_ckey [CACHE_ENTRIES];
    logic signed [VAL_W-1:0]  w_cval [CACHE_ENTRIES];
    logic signed [VAL_W-1:0]  w_hval [CACHE_ENTRIES];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_finish      = (r_state == S_RES) && w_out_free;
    assign w_access      = (r_cmd == CMD_ACCESS) && r_coords_ok;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= s_axis_tuser;
            r_key       <= w_key;
            r_coords_ok <= w_coords_ok;
            r_fill      <= w_fill_clamped;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_CMP;
            S_CMP:   n_state = S_RES;
            S_RES:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // the chain is kept in insertion order: cell 0 newest, cell held-1 oldest
    always_comb begin
        w_hit_val = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            w_hit_val = w_hit_val | w_hval[i];
        end
    end

    assign w_hit_any = |w_hit;

    always_comb begin
        if (CW'(r_cap) == '0) begin
            w_cap_eff = CW'(1);
        end else if (CW'(r_cap) > CW'(CACHE_ENTRIES)) begin
            w_cap_eff = CW'(CACHE_ENTRIES);
        end else begin
            w_cap_eff = CW'(r_cap);
        end
    end

    assign w_full = (CW'(r_held) >= w_cap_eff);

    assign w_ctrl.cmp_en = (r_state == S_CMP);
    assign w_ctrl.shift  = w_finish && w_access && !w_hit_any;

    always_comb begin
        n_held    = r_held;
        n_hits    = r_hits;
        n_misses  = r_misses;
        w_res_val = '0;
        if (r_cmd == CMD_CLR_ENTRIES) begin
            n_held = '0;
        end else if (r_cmd == CMD_CLR_COUNTS) begin
            n_hits   = '0;
            n_misses = '0;
        end else if (w_access) begin
            if (w_hit_any) begin
                w_res_val = w_hit_val;
                if (r_hits != TOTAL_MAX) n_hits = r_hits + 1'b1;
            end else begin
                w_res_val = r_fill;
                if (r_misses != TOTAL_MAX) n_misses = r_misses + 1'b1;
                // a full chain drops its oldest entry as the new one enters
                if (!w_full) n_held = r_held + 1'b1;
            end
        end
        n_out_data = {(M_TDATA_W - VAL_W - 2 - 2*TOTAL_W - HELD_W)'(0),
                      HELD_W'(n_held), n_misses, n_hits, w_access,
                      w_access && w_hit_any, w_res_val};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_hits   <= '0;
            r_misses <= '0;
        end else if (w_finish) begin
            r_held   <= n_held;
            r_hits   <= n_hits;
            r_misses <= n_misses;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    genvar g;
    generate
        for (g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
            assign w_valid[g] = (r_held > CNT_W'(g));
            if (g == 0) begin : g_head
                qkc_cell #(
                    .KEY_W(KEY_W)
                ) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctrl    (w_ctrl),
                    .i_valid   (w_valid[g]),
                    .i_cmp_key (r_key),
                    .i_key     (r_key),
                    .i_val     (r_fill),
                    .o_key     (w_ckey[g]),
                    .o_val     (w_cval[g]),
                    .o_hit     (w_hit[g]),
                    .o_hit_val (w_hval[g])
                );
            end else begin : g_body
                qkc_cell #(
                    .KEY_W(KEY_W)
                ) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctrl    (w_ctrl),
                    .i_valid   (w_valid[g]),
                    .i_cmp_key (r_key),
                    .i_key     (w_ckey[g-1]),
                    .i_val     (w_cval[g-1]),
                    .o_key     (w_ckey[g]),
                    .o_val     (w_cval[g]),
                    .o_hit     (w_hit[g]),
                    .o_hit_val (w_hval[g])
                );
            end
        end
    endgenerate

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(CACHE_ENTRIES))
        else $error("entry count beyond cache size");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES) |-> $onehot0(w_hit))
        else $error("key stored in more than one cell");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished item did not reach the output register");

    a_held_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && w_ctrl.shift) |=> (r_held != '0))
        else $error("insert left the chain empty");
`endif

endmodule

>>> sv/qkc_cell.sv
module qkc_cell
    import qkc_pkg::*;
#(
    parameter int KEY_W = 38
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctrl              i_ctrl,
    input  logic                    i_valid,
    input  logic [KEY_W-1:0]        i_cmp_key,
    input  logic [KEY_W-1:0]        i_key,
    input  logic signed [VAL_W-1:0] i_val,
    output logic [KEY_W-1:0]        o_key,
    output logic signed [VAL_W-1:0] o_val,
    output logic                    o_hit,
    output logic signed [VAL_W-1:0] o_hit_val
);

    logic [KEY_W-1:0]        r_key;
    logic signed [VAL_W-1:0] r_val;
    logic                    r_hit;
    logic signed [VAL_W-1:0] r_hit_val;
    logic                    w_match;

    assign w_match = i_valid && (r_key == i_cmp_key);

    // entry payload moves one place toward the old end on every insert
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_key <= i_key;
            r_val <= i_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.cmp_en) begin
            r_hit <= w_match;
        end
    end

    // masked so the results of all cells can simply be or-ed together
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_hit_val <= w_match ? r_val : '0;
        end
    end

    assign o_key     = r_key;
    assign o_val     = r_val;
    assign o_hit     = r_hit;
    assign o_hit_val = r_hit_val;

endmodule

>>> dv/testbench.sv
module testbench;
    import qkc_pkg::*;

    localparam int SLOTS = CACHE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 225;
    localparam int RX_HOLD_LEN = 300;
    localparam int LAT_MAX = LAT_LIMIT;
    localparam int LON_MAX = LON_LIMIT;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam int PRESS_NONE = 0;
    localparam int PRESS_RX_HOLD = 1;
    localparam int PRESS_TX_PAUSE = 2;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [FILL_W-1:0]  fill;
        logic signed [COORD_W-1:0] lon;
        logic signed [COORD_W-1:0] lat;
    } t_lookup_req;

    // same bit order as the master tdata, value in the lowest bits
    typedef struct packed {
        logic [HELD_W-1:0]       entries_held;
        logic [TOTAL_W-1:0]      miss_total;
        logic [TOTAL_W-1:0]      hit_total;
        logic                    coords_ok;
        logic                    was_hit;
        logic signed [VAL_W-1:0] value;
    } t_lookup_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [CMD_W-1:0]     s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    quantized_key_fifo_value_cache_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the cache contents and settings
    logic [63:0]             key_mem [SLOTS];
    logic signed [VAL_W-1:0] val_mem [SLOTS];
    bit                      valid_mem [SLOTS];
    int                      fifo_order [SLOTS];
    int                      held_cnt;
    logic [TOTAL_W-1:0]      hit_cnt;
    logic [TOTAL_W-1:0]      miss_cnt;
    int                      cap_reg;
    logic signed [VAL_W-1:0] floor_reg;
    logic signed [VAL_W-1:0] ceil_reg;

    t_lookup_req   lookup_queue[$];
    t_lookup_reply predicted_replies[$];
    t_lookup_req   driven_req;
    int            reqs_unaccepted = 0;
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    bit            tx_hold = 1'b0;
    int            rx_hold_left = 0;
    int            fail_count = 0;
    int            cycle_count = 0;
    int            pool_lat [128];
    int            pool_lon [128];
    int            pool_size = 1;

    function automatic void clear_entries();
        for (int i = 0; i < SLOTS; i++) begin
            valid_mem[i] = 1'b0;
            fifo_order[i] = 0;
        end
        held_cnt = 0;
    endfunction

    function automatic t_lookup_reply predict_lookup(t_lookup_req req);
        t_lookup_reply r;
        longint lat, lon, v, q_lat, q_lon;
        logic [63:0] key;
        int cap, slot, hit_slot;
        bit free_found;
        r = '0;
        lat = req.lat;
        lon = req.lon;
        if (req.cmd == CMD_CLR_ENTRIES) begin
            clear_entries();
        end else if (req.cmd == CMD_CLR_COUNTS) begin
            hit_cnt = '0;
            miss_cnt = '0;
        end else if (req.cmd == CMD_ACCESS && lat >= -LAT_MAX && lat <= LAT_MAX &&
                     lon >= -LON_MAX && lon <= LON_MAX) begin
            r.coords_ok = 1'b1;
            // quantize truncating toward zero
            q_lat = (lat < 0) ? -((-lat) >>> QUANT_SHIFT_DEF) : (lat >>> QUANT_SHIFT_DEF);
            q_lon = (lon < 0) ? -((-lon) >>> QUANT_SHIFT_DEF) : (lon >>> QUANT_SHIFT_DEF);
            key = {q_lat[31:0], q_lon[31:0]};
            hit_slot = -1;
            for (int i = 0; i < SLOTS; i++)
                if (hit_slot < 0 && valid_mem[i] && key_mem[i] == key)
                    hit_slot = i;
            if (hit_slot >= 0) begin
                if (hit_cnt != TOTAL_MAX)
                    hit_cnt = hit_cnt + 1;
                r.value = val_mem[hit_slot];
                r.was_hit = 1'b1;
            end else begin
                if (miss_cnt != TOTAL_MAX)
                    miss_cnt = miss_cnt + 1;
                v = req.fill;
                if (v > ceil_reg)
                    v = ceil_reg;
                if (v < floor_reg)
                    v = floor_reg;
                cap = cap_reg;
                if (cap < 1)
                    cap = 1;
                if (cap > SLOTS)
                    cap = SLOTS;
                slot = 0;
                free_found = 1'b0;
                // full: drop only the oldest entry, even when held exceeds capacity
                if (held_cnt >= cap && held_cnt > 0) begin
                    slot = fifo_order[0] % SLOTS;
                    valid_mem[slot] = 1'b0;
                    for (int i = 0; i + 1 < held_cnt; i++)
                        fifo_order[i] = fifo_order[i + 1];
                    held_cnt--;
                    free_found = 1'b1;
                end
                if (!free_found)
                    for (int i = 0; i < SLOTS; i++)
                        if (!free_found && !valid_mem[i]) begin
                            slot = i;
                            free_found = 1'b1;
                        end
                if (free_found && held_cnt < SLOTS) begin
                    key_mem[slot] = key;
                    val_mem[slot] = v[VAL_W-1:0];
                    valid_mem[slot] = 1'b1;
                    fifo_order[held_cnt] = slot;
                    held_cnt++;
                end
                r.value = v[VAL_W-1:0];
            end
        end
        r.hit_total = hit_cnt;
        r.miss_total = miss_cnt;
        r.entries_held = held_cnt[HELD_W-1:0];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_replies = {predicted_replies, predict_lookup(driven_req)};
                reqs_unaccepted--;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (lookup_queue.size() > 0 && !tx_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    driven_req = lookup_queue[0];
                    lookup_queue.delete(0);
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= S_TDATA_W'({driven_req.fill, driven_req.lon, driven_req.lat});
                    s_axis_tuser <= driven_req.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_lookup_reply got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(t_lookup_reply)-1:0];
                if (predicted_replies.size() == 0) begin
                    $display("%0t: unexpected reply", $time,
                             " value=%0d hit=%0b ok=%0b", got.value, got.was_hit,
                             got.coords_ok, " hits=%0d misses=%0d held=%0d",
                             got.hit_total, got.miss_total, got.entries_held);
                    fail_count++;
                end else begin
                    want = predicted_replies[0];
                    predicted_replies.delete(0);
                    if (got.value !== want.value || got.was_hit !== want.was_hit ||
                        got.coords_ok !== want.coords_ok || got.hit_total !== want.hit_total ||
                        got.miss_total !== want.miss_total ||
                        got.entries_held !== want.entries_held) begin
                        $display("%0t: mismatch expected", $time,
                                 " value=%0d hit=%0b ok=%0b", want.value, want.was_hit,
                                 want.coords_ok, " hits=%0d misses=%0d held=%0d",
                                 want.hit_total, want.miss_total, want.entries_held);
                        $display("%0t:          actual", $time,
                                 " value=%0d hit=%0b ok=%0b", got.value, got.was_hit,
                                 got.coords_ok, " hits=%0d misses=%0d held=%0d",
                                 got.hit_total, got.miss_total, got.entries_held);
                        fail_count++;
                    end
                end
            end
            if (rx_hold_left > 0)
                rx_hold_left <= rx_hold_left - 1;
            m_axis_tready <= (rx_hold_left <= 1) && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[quantized_key_fifo_value_cache_unit] ERROR");
            $finish;
        end
    end

    task automatic send_lookup(logic [CMD_W-1:0] cmd, int lat, int lon, int fill);
        t_lookup_req req;
        req.cmd = cmd;
        req.lat = COORD_W'(lat);
        req.lon = COORD_W'(lon);
        req.fill = FILL_W'(fill);
        reqs_unaccepted++;
        lookup_queue = {lookup_queue, req};
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (reqs_unaccepted != 0 || predicted_replies.size() != 0);
    endtask

    task automatic write_limits(int cap, int floor_v, int ceil_v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_CAPACITY;
        i_cfg_data <= CFG_W'(cap);
        @(posedge i_clk);
        i_cfg_idx <= REG_FLOOR;
        i_cfg_data <= CFG_W'(floor_v);
        @(posedge i_clk);
        i_cfg_idx <= REG_CEILING;
        i_cfg_data <= CFG_W'(ceil_v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cap_reg = cap & 'h7F;
        floor_reg = VAL_W'(floor_v);
        ceil_reg = VAL_W'(ceil_v);
    endtask

    task automatic random_lookups(int n);
        int roll, idx, lat, lon, fill;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            fill = $urandom();
            if ($urandom_range(3) == 0)
                fill = int'(floor_reg) + $urandom_range(8) - 4;
            if (roll < 65) begin
                // revisit a known point, jitter may or may not cross a cell
                idx = $urandom_range(pool_size - 1);
                lat = pool_lat[idx] + $urandom_range(80) - 40;
                lon = pool_lon[idx] + $urandom_range(80) - 40;
                send_lookup(CMD_ACCESS, lat, lon, fill);
            end else if (roll < 80) begin
                lat = $urandom_range(2 * LAT_MAX) - LAT_MAX;
                lon = $urandom_range(2 * LON_MAX) - LON_MAX;
                send_lookup(CMD_ACCESS, lat, lon, fill);
            end else if (roll < 91) begin
                send_lookup(CMD_ACCESS, $urandom(), $urandom(), fill);
            end else if (roll < 94) begin
                send_lookup(CMD_CLR_COUNTS, $urandom(), $urandom(), fill);
            end else if (roll < 96) begin
                send_lookup(CMD_CLR_ENTRIES, $urandom(), $urandom(), fill);
            end else begin
                send_lookup(CMD_SPARE, $urandom(), $urandom(), fill);
            end
        end
    endtask

    task automatic run_phase(int cap, int floor_v, int ceil_v, int send_pct, int rx_pct,
                             int pressure);
        int cap_eff;
        wait_drained();
        write_limits(cap, floor_v, ceil_v);
        send_idle_pct = send_pct;
        stall_pct = rx_pct;
        cap_eff = (cap < 1) ? 1 : (cap > SLOTS) ? SLOTS : cap;
        pool_size = cap_eff + 1 + $urandom_range(cap_eff);
        if (pool_size > 128)
            pool_size = 128;
        for (int i = 0; i < pool_size; i++) begin
            pool_lat[i] = $urandom_range(2 * (LAT_MAX - 64)) - (LAT_MAX - 64);
            pool_lon[i] = $urandom_range(2 * (LON_MAX - 64)) - (LON_MAX - 64);
        end
        random_lookups(PHASE_ITEMS / 2);
        if (pressure == PRESS_TX_PAUSE) begin
            // let part of the batch go out before the sender stops
            do @(posedge i_clk);
            while (reqs_unaccepted > PHASE_ITEMS / 4);
            tx_hold = 1'b1;
            do @(posedge i_clk);
            while (predicted_replies.size() != 0 || s_axis_tvalid);
            tx_hold = 1'b0;
        end
        random_lookups(PHASE_ITEMS - PHASE_ITEMS / 2);
        if (pressure == PRESS_RX_HOLD) begin
            do @(posedge i_clk);
            while (reqs_unaccepted > PHASE_ITEMS - 20);
            // sink goes quiet while items keep coming, input must back up
            rx_hold_left = RX_HOLD_LEN;
        end
    endtask

    initial begin
        hit_cnt = '0;
        miss_cnt = '0;
        clear_entries();
        cap_reg = CAP_RESET;
        floor_reg = FLOOR_RESET;
        ceil_reg = CEIL_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // limits, truncation toward zero, other commands
        send_lookup(CMD_SPARE, LAT_MAX, LON_MAX, 1);
        send_lookup(CMD_ACCESS, LAT_MAX, LON_MAX, 8388607);
        send_lookup(CMD_ACCESS, LAT_MAX, LON_MAX, 3);
        send_lookup(CMD_ACCESS, -LAT_MAX, -LON_MAX, -8388608);
        send_lookup(CMD_ACCESS, LAT_MAX + 1, 0, 9);
        send_lookup(CMD_ACCESS, -LAT_MAX - 1, 0, 9);
        send_lookup(CMD_ACCESS, 0, LON_MAX + 1, 9);
        send_lookup(CMD_ACCESS, 0, -LON_MAX - 1, 9);
        send_lookup(CMD_ACCESS, 'hFFFFFF, -16777216, 9);
        send_lookup(CMD_ACCESS, 63, -63, 5);
        send_lookup(CMD_ACCESS, -63, 0, 7);
        send_lookup(CMD_CLR_COUNTS, 0, 0, 0);
        send_lookup(CMD_CLR_ENTRIES, 0, 0, 0);
        send_lookup(CMD_ACCESS, 64, 0, 11);
        send_lookup(CMD_ACCESS, -64, 0, 12);
        send_lookup(CMD_ACCESS, 0, 64, -13);
        send_lookup(CMD_ACCESS, 0, -64, 14);
        send_lookup(CMD_ACCESS, 0, 0, 0);
        wait_drained();

        // capacity below entries held, floor above ceiling
        write_limits(2, 1000, -1000);
        send_lookup(CMD_ACCESS, 1000, 1000, 0);
        send_lookup(CMD_ACCESS, 64, 0, 0);
        send_lookup(CMD_ACCESS, 0, 0, 0);
        send_lookup(CMD_ACCESS, -64, 0, 2000);

        run_phase(64, -1048576, 1048575, 0, 0, PRESS_RX_HOLD);
        run_phase(1, -1048576, 1048575, 74, 0, PRESS_NONE);
        run_phase(8, -500, 500, 0, 74, PRESS_NONE);
        run_phase(0, $urandom(), $urandom(), 14, 14, PRESS_NONE);
        run_phase(100, 1048575, -1048576, 0, 0, PRESS_TX_PAUSE);
        cap_reg = $urandom();
        run_phase(32, cap_reg, cap_reg, 74, 0, PRESS_NONE);
        run_phase($urandom_range(63, 2), $urandom(), $urandom(), 0, 74, PRESS_NONE);
        run_phase(64, -$urandom_range(1048576), $urandom_range(1048575), 14, 14,
                  PRESS_NONE);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (predicted_replies.size() != 0) begin
            $display("%0t: %0d replies never arrived", $time, predicted_replies.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("[quantized_key_fifo_value_cache_unit] OK");
        else
            $display("[quantized_key_fifo_value_cache_unit] ERROR");
        $finish;
    end

endmodule
